// ===== src/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and codes for the sparse polynomial add/subtract block.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int SPA_MAX_TERMS = 32;
    localparam int COEF_W        = 32;
    localparam int EXP_W         = 16;
    localparam int RCOEF_W       = 33;
    localparam int TERM_W        = COEF_W + EXP_W;

    typedef enum logic [2:0] {
        CMD_LOAD_A = 3'd0,
        CMD_LOAD_B = 3'd1,
        CMD_SUM    = 3'd2,
        CMD_DIFF   = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_EMIT    = 3'd0,
        STAT_STORED  = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_CLEARED = 3'd3,
        STAT_NONE    = 3'd4
    } stat_t;

    typedef enum logic {
        S_IDLE,
        S_MERGE
    } state_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]         exponent;
    } in_t;

    typedef struct packed {
        logic signed [RCOEF_W-1:0] result_coefficient;
        logic [EXP_W-1:0]          result_exponent;
        logic [2:0]                status;
        logic                      last;
    } out_t;

    typedef struct packed {
        logic merging;
        logic load_a;
        logic load_b;
        logic clear;
        logic emit_none;
        logic merge_start;
        logic merge_step;
        logic subtract;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic both_empty;
        logic merge_last;
    } dp_sts_t;

endpackage

// ===== src/spa_ram.sv =====
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/spa_ctrl.sv =====
// ----------------------------------------------------------------------------
// spa_ctrl
// Controller: accepts items, decodes commands and sequences the merge walk.
// ----------------------------------------------------------------------------
module spa_ctrl import spa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [2:0] command,
    input  dp_sts_t   sts,
    output ctl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = sts.out_free;
                accept  = s_valid && sts.out_free;
                if (accept) begin
                    unique case (command)
                        CMD_LOAD_A: cmd.load_a = 1'b1;
                        CMD_LOAD_B: cmd.load_b = 1'b1;
                        CMD_CLEAR:  cmd.clear  = 1'b1;
                        CMD_SUM, CMD_DIFF: begin
                            cmd.subtract = (command == CMD_DIFF);
                            if (sts.both_empty) begin
                                cmd.emit_none = 1'b1;
                            end else begin
                                cmd.merge_start = 1'b1;
                                state_next      = S_MERGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MERGE: begin
                cmd.merging = 1'b1;
                if (sts.out_free) begin
                    cmd.merge_step = 1'b1;
                    if (sts.merge_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/spa_dp.sv =====
// ----------------------------------------------------------------------------
// spa_dp
// Datapath: term stores, fill counts, merge indices, combiner and result
// register.
// ----------------------------------------------------------------------------
module spa_dp import spa_pkg::*; #(
    parameter int MAX_TERMS = SPA_MAX_TERMS,
    localparam int AW       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
    localparam int CW       = $clog2(MAX_TERMS + 1)
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_t      s_data,
    input  ctl_cmd_t cmd,
    output dp_sts_t  sts,
    output logic     m_valid,
    input  logic     m_ready,
    output out_t     m_data
);

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic          sub_reg, sub_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_data_reg, out_data_next;

    logic              full_a, full_b;
    logic              we_a, we_b;
    logic [TERM_W-1:0] wdata, rdata_a, rdata_b;
    logic [AW-1:0]     raddr_a, raddr_b;

    logic                       live_a, live_b, take_a, take_b;
    logic [EXP_W-1:0]           exp_a, exp_b;
    logic signed [RCOEF_W-1:0]  ca, cb, cb_eff, sum;
    logic [CW-1:0]              adv_a, adv_b;

    assign full_a = (count_a_reg == CW'(MAX_TERMS));
    assign full_b = (count_b_reg == CW'(MAX_TERMS));
    assign we_a   = cmd.load_a && !full_a;
    assign we_b   = cmd.load_b && !full_b;
    assign wdata  = {s_data.coefficient, s_data.exponent};

    spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign exp_a  = rdata_a[EXP_W-1:0];
    assign exp_b  = rdata_b[EXP_W-1:0];
    assign ca     = RCOEF_W'($signed(rdata_a[TERM_W-1:EXP_W]));
    assign cb     = RCOEF_W'($signed(rdata_b[TERM_W-1:EXP_W]));
    assign cb_eff = sub_reg ? -cb : cb;

    assign live_a = (idx_a_reg < count_a_reg);
    assign live_b = (idx_b_reg < count_b_reg);
    assign take_a = live_a && (!live_b || (exp_a >= exp_b));
    assign take_b = live_b && (!live_a || (exp_b >= exp_a));
    assign sum    = (take_a ? ca : '0) + (take_b ? cb_eff : '0);
    assign adv_a  = idx_a_reg + CW'(take_a);
    assign adv_b  = idx_b_reg + CW'(take_b);

    assign sts.out_free   = !out_valid_reg || m_ready;
    assign sts.both_empty = (count_a_reg == '0) && (count_b_reg == '0);
    assign sts.merge_last = (adv_a >= count_a_reg) && (adv_b >= count_b_reg);

    always_comb begin
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        if (cmd.load_a || cmd.load_b || cmd.clear || cmd.emit_none || cmd.merge_step) begin
            out_valid_next                   = 1'b1;
            out_data_next.result_coefficient = '0;
            out_data_next.result_exponent    = '0;
            out_data_next.last               = 1'b1;
        end

        if (cmd.load_a) begin
            out_data_next.status = full_a ? STAT_FULL : STAT_STORED;
            if (!full_a) begin
                count_a_next = count_a_reg + 1'b1;
            end
        end
        if (cmd.load_b) begin
            out_data_next.status = full_b ? STAT_FULL : STAT_STORED;
            if (!full_b) begin
                count_b_next = count_b_reg + 1'b1;
            end
        end
        if (cmd.clear) begin
            count_a_next         = '0;
            count_b_next         = '0;
            out_data_next.status = STAT_CLEARED;
        end
        if (cmd.emit_none) begin
            out_data_next.status = STAT_NONE;
        end
        if (cmd.merge_start) begin
            idx_a_next = '0;
            idx_b_next = '0;
            sub_next   = cmd.subtract;
        end
        if (cmd.merge_step) begin
            idx_a_next                       = adv_a;
            idx_b_next                       = adv_b;
            out_data_next.result_coefficient = sum;
            out_data_next.result_exponent    = take_a ? exp_a : exp_b;
            out_data_next.status             = STAT_EMIT;
            out_data_next.last               = sts.merge_last;
        end
    end

    assign raddr_a = cmd.merging ? idx_a_next[AW-1:0] : '0;
    assign raddr_b = cmd.merging ? idx_b_next[AW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            out_valid_reg <= out_valid_next;
        end
        idx_a_reg    <= idx_a_next;
        idx_b_reg    <= idx_b_next;
        sub_reg      <= sub_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/sparse_polynomial_add_sub.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_add_sub
// Two term stores merged into a sum or difference, one term per result item.
// ----------------------------------------------------------------------------
// Load and clear items give one result each; a new item is taken in the next
// cycle as long as the result register is free or being drained. A sum or
// difference item gives one result per merged term, and there are at most
// count_a + count_b of them: each store has one registered read port, and the
// merge walk consumes the head of A, of B or of both once per cycle, so one
// term leaves per cycle while the result channel keeps up.
// Stores that are empty on an emit item give a single result with nothing to
// emit. Input items are not taken while a merge walk is under way.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_sub import spa_pkg::*; #(
    parameter int MAX_TERMS = SPA_MAX_TERMS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    spa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .command (s_data.command),
        .sts     (sts),
        .cmd     (cmd)
    );

    spa_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_load_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.command == CMD_LOAD_A ||
            s_data.command == CMD_LOAD_B || s_data.command == CMD_CLEAR)
        |=> m_valid && m_data.last && m_data.status != STAT_EMIT)
        else $error("load or clear item gave no final result");

    a_nonemit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_EMIT |-> m_data.last &&
            m_data.result_coefficient == '0 && m_data.result_exponent == '0)
        else $error("non-term result not final or not zeroed");

    a_busy_mid_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |-> !s_ready)
        else $error("input taken before merge finished");
`endif

endmodule

// ===== tb/polynomial_merge_checker.sv =====
// ----------------------------------------------------------------------------
// polynomial_merge_checker
// Watches both channels of the sparse polynomial add/subtract block. Every
// accepted input item with a defined command updates or reads a private copy
// of the two term stores and queues the terms the block must answer with.
// Every accepted result is checked field by field against the oldest queued
// term. Mismatches and results that arrive with nothing queued are counted.
// ----------------------------------------------------------------------------
module polynomial_merge_checker import spa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   error_count,
    output int   pending_terms
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [COEF_W-1:0] a_coef [SPA_MAX_TERMS];
    logic [EXP_W-1:0]         a_exp  [SPA_MAX_TERMS];
    int unsigned              a_count;
    logic signed [COEF_W-1:0] b_coef [SPA_MAX_TERMS];
    logic [EXP_W-1:0]         b_exp  [SPA_MAX_TERMS];
    int unsigned              b_count;

    out_t expected_terms [$];

    function automatic out_t make_term(logic signed [RCOEF_W-1:0] coef,
                                       logic [EXP_W-1:0] expo, stat_t st, logic fin);
        out_t t;
        t.result_coefficient = coef;
        t.result_exponent    = expo;
        t.status             = st;
        t.last               = fin;
        return t;
    endfunction

    task automatic merge_terms(bit subtract);
        int unsigned      i;
        int unsigned      j;
        int               emitted;
        longint           coef;
        longint           sign_b;
        logic [EXP_W-1:0] expo;
        i       = 0;
        j       = 0;
        emitted = 0;
        sign_b  = subtract ? -1 : 1;
        while (i < a_count || j < b_count) begin
            if (i < a_count && (j >= b_count || a_exp[i] > b_exp[j])) begin
                coef = a_coef[i];
                expo = a_exp[i];
                i++;
            end else if (j < b_count && (i >= a_count || b_exp[j] > a_exp[i])) begin
                coef = sign_b * b_coef[j];
                expo = b_exp[j];
                j++;
            end else begin
                coef = longint'(a_coef[i]) + sign_b * b_coef[j];
                expo = a_exp[i];
                i++;
                j++;
            end
            expected_terms.push_back(make_term(coef[RCOEF_W-1:0], expo, STAT_EMIT,
                                               (i >= a_count && j >= b_count)));
            emitted++;
        end
        if (emitted == 0) begin
            expected_terms.push_back(make_term('0, '0, STAT_NONE, 1'b1));
        end
    endtask

    task automatic predict_item(in_t it);
        case (it.command)
            CMD_LOAD_A: begin
                if (a_count >= SPA_MAX_TERMS) begin
                    expected_terms.push_back(make_term('0, '0, STAT_FULL, 1'b1));
                end else begin
                    a_coef[a_count] = it.coefficient;
                    a_exp[a_count]  = it.exponent;
                    a_count++;
                    expected_terms.push_back(make_term('0, '0, STAT_STORED, 1'b1));
                end
            end
            CMD_LOAD_B: begin
                if (b_count >= SPA_MAX_TERMS) begin
                    expected_terms.push_back(make_term('0, '0, STAT_FULL, 1'b1));
                end else begin
                    b_coef[b_count] = it.coefficient;
                    b_exp[b_count]  = it.exponent;
                    b_count++;
                    expected_terms.push_back(make_term('0, '0, STAT_STORED, 1'b1));
                end
            end
            CMD_SUM:  merge_terms(1'b0);
            CMD_DIFF: merge_terms(1'b1);
            CMD_CLEAR: begin
                a_count = 0;
                b_count = 0;
                expected_terms.push_back(make_term('0, '0, STAT_CLEARED, 1'b1));
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            a_count = 0;
            b_count = 0;
            expected_terms.delete();
            error_count   <= 0;
            pending_terms <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_terms.size() == 0) begin
                    $display("%0t: unexpected result: coef %0d exp %0d status %0d last %0d",
                             $time, m_data.result_coefficient, m_data.result_exponent,
                             m_data.status, m_data.last);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_terms.pop_front();
                    if (m_data.result_coefficient !== want.result_coefficient ||
                        m_data.result_exponent !== want.result_exponent ||
                        m_data.status !== want.status ||
                        m_data.last !== want.last) begin
                        $display("%0t: mismatch: expected coef %0d exp %0d status %0d last %0d,",
                                 $time, want.result_coefficient, want.result_exponent,
                                 want.status, want.last,
                                 " got coef %0d exp %0d status %0d last %0d",
                                 m_data.result_coefficient, m_data.result_exponent,
                                 m_data.status, m_data.last);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_item(s_data);
            end
            pending_terms <= expected_terms.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sparse polynomial add/subtract block. A directed run covers
// empty stores, coefficient and exponent extremes, cancellation, negated terms
// of B, unsorted stores and unused commands. Random load-and-merge sequences
// follow, one of them overfilling both stores, under phases of sender idling
// and receiver stalls. The checker beside the block reports the failures.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spa_pkg::*;

    localparam int          CYCLE_LIMIT      = 500000;
    localparam int          TAIL_CYCLES      = 2 * SPA_MAX_TERMS + 10;
    localparam int          PHASE_ITEMS      = 5;
    localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
    localparam logic [31:0] COEF_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN         = 32'h8000_0000;
    localparam logic [15:0] EXP_TOP          = 16'hFFFF;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int error_count;
    int pending_terms;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;
    int cycle_count        = 0;

    sparse_polynomial_add_sub #(
        .MAX_TERMS(SPA_MAX_TERMS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    polynomial_merge_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .pending_terms (pending_terms)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(logic [2:0] cmd, logic [31:0] coef, logic [15:0] expo);
        in_t it;
        it.command     = cmd;
        it.coefficient = coef;
        it.exponent    = expo;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (cmd <= CMD_CLEAR) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_terms != 0);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(7))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] next_exp(logic [15:0] expo, bit sorted);
        int step;
        step = $urandom_range(1, 3);
        if (!sorted || expo < step) begin
            return 16'($urandom);
        end
        return 16'(expo - step);
    endfunction

    task automatic random_sequence(bit fill_stores);
        int          na;
        int          nb;
        int          ka;
        int          kb;
        bit          sorted;
        logic [15:0] ea;
        logic [15:0] eb;
        logic [2:0]  op;
        if (!fill_stores && $urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_item(3'($urandom_range(7)), $urandom, 16'($urandom));
            end
            return;
        end
        if (fill_stores || $urandom_range(3) != 0) begin
            send_item(CMD_CLEAR, $urandom, 16'($urandom));
        end
        na     = fill_stores ? SPA_MAX_TERMS + 1 : $urandom_range(0, 5);
        nb     = fill_stores ? SPA_MAX_TERMS + 1 : $urandom_range(0, 5);
        sorted = fill_stores || ($urandom_range(4) != 0);
        ea     = ($urandom_range(7) == 0) ? EXP_TOP : 16'($urandom);
        eb     = ea;
        ka     = 0;
        kb     = 0;
        while (ka < na || kb < nb) begin
            if (kb >= nb || (ka < na && $urandom_range(1) == 1)) begin
                send_item(CMD_LOAD_A, pick_coef(), ea);
                ea = next_exp(ea, sorted);
                ka++;
            end else begin
                send_item(CMD_LOAD_B, pick_coef(), eb);
                eb = next_exp(eb, sorted);
                kb++;
            end
            if (!fill_stores && $urandom_range(19) == 0) begin
                send_item(3'($urandom_range(CMD_SUM, CMD_UNUSED_LAST)), $urandom,
                          16'($urandom));
            end
        end
        op = 3'($urandom_range(CMD_SUM, CMD_DIFF));
        send_item(op, $urandom, 16'($urandom));
        if (fill_stores || $urandom_range(1) == 1) begin
            send_item((op == CMD_SUM) ? CMD_DIFF : CMD_SUM, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        int target;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(CMD_CLEAR, 32'd0, 16'd0);
        send_item(CMD_SUM, COEF_MAX, EXP_TOP);
        send_item(CMD_DIFF, COEF_MIN, EXP_TOP);
        send_item(CMD_LOAD_A, COEF_MAX, EXP_TOP);
        send_item(CMD_LOAD_A, COEF_MIN, 16'd100);
        send_item(CMD_LOAD_A, 32'd5, 16'd0);
        send_item(CMD_LOAD_B, COEF_MAX, EXP_TOP);
        send_item(CMD_LOAD_B, COEF_MAX, 16'd100);
        send_item(CMD_LOAD_B, COEF_MIN, 16'd50);
        send_item(CMD_LOAD_B, -32'sd5, 16'd0);
        send_item(CMD_SUM, 32'd0, 16'd0);
        send_item(CMD_DIFF, 32'd0, 16'd0);
        send_item(CMD_UNUSED_FIRST, $urandom, 16'($urandom));
        send_item(CMD_UNUSED_FIRST + 3'd1, $urandom, 16'($urandom));
        send_item(CMD_UNUSED_LAST, $urandom, 16'($urandom));
        send_item(CMD_SUM, 32'd0, 16'd0);
        send_item(CMD_CLEAR, 32'd0, 16'd0);
        send_item(CMD_LOAD_A, COEF_MIN, 16'd7);
        send_item(CMD_LOAD_B, COEF_MIN, 16'd7);
        send_item(CMD_LOAD_A, COEF_MAX, 16'd3);
        send_item(CMD_LOAD_B, COEF_MAX, 16'd3);
        send_item(CMD_SUM, 32'd0, 16'd0);
        send_item(CMD_DIFF, 32'd0, 16'd0);
        send_item(CMD_LOAD_A, 32'd9, 16'd9);
        send_item(CMD_SUM, 32'd0, 16'd0);

        random_sequence(1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct    = 74;
                    receiver_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 74;
                end
                default: begin
                    sender_idle_pct    = 20;
                    receiver_stall_pct <= 20;
                end
            endcase
            wait_drained();
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                random_sequence(1'b0);
            end
        end

        receiver_stall_pct <= 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_terms == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
